// ===== design/tird_pkg.sv =====
// Package of the tape-image record deframer: widths, phase and status codes,
// and the command word that travels from the front end to the record engine.
// No dependencies.
package tird_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_DATA    = 4'b0010,
        PH_TRAILER = 4'b0100,
        PH_EXTRA   = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EOT      = 3'd1,
        ST_LONG     = 3'd2,
        ST_NODATA   = 3'd3,
        ST_TRAILEOF = 3'd4,
        ST_MISMATCH = 3'd5
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic       eof;
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== design/tird_if.sv =====
// Stream channel interfaces of the tape-image record deframer: one for the
// incoming byte stream and one for the outgoing words. Uses no package.
interface tird_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface tird_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [31:0] header_length;
    logic [15:0] delivered_count;

    modport source (output valid, output kind, output data_byte, output status,
                    output header_length, output delivered_count, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input header_length, input delivered_count, output ready);
endinterface

// ===== design/tird_front.sv =====
// Front end of the deframer: takes words from the input channel, classifies
// them as stream byte or end of file and hands a command to the queue.
// Depends on tird_pkg and tird_if.
module tird_front (
    tird_in_if.sink        i_in_ch,
    input  logic           i_q_ready,
    output logic           o_q_push,
    output tird_pkg::t_cmd o_q_cmd
);

    assign i_in_ch.ready = i_q_ready;
    assign o_q_push      = i_in_ch.valid && i_q_ready;

    // An end of file carries a zero byte, which the extra-byte compare relies on.
    always_comb begin
        o_q_cmd.eof  = i_in_ch.action;
        o_q_cmd.data = i_in_ch.action ? 8'd0 : i_in_ch.byte_value;
    end

endmodule

// ===== design/tird_queue.sv =====
// Short command queue between the front end and the record engine.
// Depends on tird_pkg.
module tird_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tird_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output tird_pkg::t_cmd o_cmd
);

    tird_pkg::t_cmd r_mem [tird_pkg::Q_DEPTH];
    logic [tird_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [tird_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [tird_pkg::Q_CNT_W-1:0] r_count;

    assign o_ready = (r_count != tird_pkg::Q_CNT_W'(tird_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == tird_pkg::Q_PTR_W'(tird_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == tird_pkg::Q_PTR_W'(tird_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/tird_back.sv =====
// Record engine of the deframer: runs the header, data, trailer and extra-byte
// phases on queued commands and holds the output word register.
// Depends on tird_pkg and tird_if.
module tird_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_q_valid,
    input  tird_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    tird_out_if.source     o_out_ch
);

    tird_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_idx, n_idx;
    logic [31:0]      r_length, n_length;
    tird_pkg::t_count r_remaining, n_remaining;
    tird_pkg::t_count r_delivered, n_delivered;
    logic [31:0]      r_trailer, n_trailer;
    logic [15:0]      r_max_len;

    logic             r_out_valid, n_out_valid;
    tird_pkg::t_kind  r_kind, n_kind;
    logic [7:0]       r_data_byte, n_data_byte;
    tird_pkg::t_status r_status, n_status;
    logic [31:0]      r_hdr_len, n_hdr_len;
    logic [15:0]      r_dcount, n_dcount;

    logic             res_valid;
    logic [31:0]      assembled;
    logic [31:0]      window;
    logic [4:0]       shift;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_out_ch.ready);

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.kind            = r_kind;
    assign o_out_ch.data_byte       = r_data_byte;
    assign o_out_ch.status          = r_status;
    assign o_out_ch.header_length   = r_hdr_len;
    assign o_out_ch.delivered_count = r_dcount;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_delivered = r_delivered;
        n_trailer   = r_trailer;
        res_valid   = 1'b0;
        n_kind      = tird_pkg::KIND_STATUS;
        n_data_byte = 8'd0;
        n_status    = tird_pkg::ST_OK;
        n_hdr_len   = r_length;
        n_dcount    = 16'(r_delivered);
        shift       = {r_idx[1:0], 3'b000};
        assembled   = 32'd0;
        window      = {i_q_cmd.data, r_trailer[31:8]};

        if (o_q_pop) begin
            unique case (r_phase)
                tird_pkg::PH_DATA: begin
                    res_valid = 1'b1;
                    if (i_q_cmd.eof) begin
                        n_status = (r_delivered == '0) ? tird_pkg::ST_NODATA
                                                       : tird_pkg::ST_TRAILEOF;
                        n_phase  = tird_pkg::PH_HEADER;
                        n_idx    = 3'd0;
                    end else begin
                        n_delivered = r_delivered + 1'b1;
                        n_remaining = r_remaining - 1'b1;
                        if (r_remaining == tird_pkg::t_count'(1)) begin
                            n_phase   = tird_pkg::PH_TRAILER;
                            n_idx     = 3'd0;
                            n_trailer = 32'd0;
                        end
                        n_kind      = tird_pkg::KIND_DATA;
                        n_data_byte = i_q_cmd.data;
                        n_dcount    = 16'(n_delivered);
                    end
                end
                tird_pkg::PH_TRAILER: begin
                    if (i_q_cmd.eof) begin
                        res_valid = 1'b1;
                        n_status  = tird_pkg::ST_TRAILEOF;
                        n_phase   = tird_pkg::PH_HEADER;
                        n_idx     = 3'd0;
                    end else begin
                        assembled = r_trailer | (32'(i_q_cmd.data) << shift);
                        n_trailer = assembled;
                        n_idx     = r_idx + 3'd1;
                        if (r_idx[1:0] == 2'd3) begin
                            if (assembled == r_length) begin
                                res_valid = 1'b1;
                                n_status  = tird_pkg::ST_OK;
                                n_phase   = tird_pkg::PH_HEADER;
                                n_idx     = 3'd0;
                            end else begin
                                n_phase = tird_pkg::PH_EXTRA;
                            end
                        end
                    end
                end
                tird_pkg::PH_EXTRA: begin
                    // Slide the trailer window by one byte and compare again.
                    res_valid = 1'b1;
                    n_status  = (window == r_length) ? tird_pkg::ST_OK
                                                     : tird_pkg::ST_MISMATCH;
                    n_phase   = tird_pkg::PH_HEADER;
                    n_idx     = 3'd0;
                end
                default: begin
                    if (i_q_cmd.eof) begin
                        // A partially collected header is dropped.
                        res_valid   = 1'b1;
                        n_delivered = '0;
                        n_status    = tird_pkg::ST_EOT;
                        n_hdr_len   = 32'd0;
                        n_dcount    = 16'd0;
                        n_phase     = tird_pkg::PH_HEADER;
                        n_idx       = 3'd0;
                    end else begin
                        assembled = ((r_idx == 3'd0) ? 32'd0 : r_length)
                                    | (32'(i_q_cmd.data) << shift);
                        n_length  = assembled;
                        n_idx     = r_idx + 3'd1;
                        if (r_idx[1:0] == 2'd3) begin
                            n_delivered = '0;
                            n_dcount    = 16'd0;
                            n_idx       = 3'd0;
                            if (assembled > {16'd0, r_max_len} ||
                                assembled > tird_pkg::COUNT_MAX) begin
                                res_valid = 1'b1;
                                n_status  = tird_pkg::ST_LONG;
                                n_hdr_len = assembled;
                            end else if (assembled == 32'd0) begin
                                res_valid = 1'b1;
                                n_status  = tird_pkg::ST_OK;
                                n_hdr_len = 32'd0;
                            end else begin
                                n_remaining = assembled[tird_pkg::COUNT_WIDTH-1:0];
                                n_phase     = tird_pkg::PH_DATA;
                            end
                        end
                    end
                end
            endcase
        end

        if (o_q_pop) begin
            n_out_valid = res_valid;
        end else begin
            n_out_valid = r_out_valid && !o_out_ch.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tird_pkg::PH_HEADER;
            r_idx       <= 3'd0;
            r_length    <= 32'd0;
            r_remaining <= '0;
            r_delivered <= '0;
            r_trailer   <= 32'd0;
            r_max_len   <= tird_pkg::MAX_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_delivered <= n_delivered;
            r_trailer   <= n_trailer;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && res_valid) begin
            r_kind      <= n_kind;
            r_data_byte <= n_data_byte;
            r_status    <= n_status;
            r_hdr_len   <= n_hdr_len;
            r_dcount    <= n_dcount;
        end
    end

endmodule

// ===== design/tape_image_record_deframer.sv =====
// Tape-image record deframer: one input word per cycle while the queue has
// room and one output word a cycle while the output side is ready; each input
// word is held in the queue, then the record engine's output register takes
// its result, if any. The two-entry queue and the output register let either
// side stall alone. Synchronous active-low reset empties the queue, drops any
// pending output, returns to awaiting a header and sets max_len to 65535.
module tape_image_record_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    tird_in_if.sink     i_in_ch,
    tird_out_if.source  o_out_ch
);

    logic           q_push;
    logic           q_ready;
    logic           q_pop;
    logic           q_valid;
    tird_pkg::t_cmd q_in_cmd;
    tird_pkg::t_cmd q_out_cmd;

    tird_front u_front (
        .i_in_ch   (i_in_ch),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in_cmd)
    );

    tird_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    tird_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_ch    (o_out_ch)
    );

endmodule
